// ===== rtl/range_sample_triple_averager_assert.svh =====
// Assertion macros shared by the range sample triple averager.
`ifndef RANGE_SAMPLE_TRIPLE_AVERAGER_ASSERT_SVH
`define RANGE_SAMPLE_TRIPLE_AVERAGER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSTA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsta_pkg.sv =====
// Shared types and constants of the range sample triple averager.
package rsta_pkg;

    localparam int DATA_W     = 16;
    localparam int WEIGHT_W   = 10;
    localparam int SCALE_SHIFT = 12;
    localparam int MAG_W      = 26;
    localparam int DIV_W      = WEIGHT_W + 1;
    localparam int DIV_STEPS  = MAG_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W  = 2;

    localparam logic [WEIGHT_W-1:0] MED_WEIGHT = WEIGHT_W'(10);

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_WEIGHT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_WEIGHT     = 2'd3;

    typedef enum logic [1:0] {
        AVG_FAST   = 2'd0,
        AVG_MEDIUM = 2'd1,
        AVG_SLOW   = 2'd2
    } t_avg_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_dist;
        logic     calc_dist;
        logic     mul_avg;
        logic     form_num;
        logic     div_step;
        logic     write_avg;
        logic     fault;
        logic     load_out;
        t_avg_sel avg_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic sample_ok;
        logic div_done;
    } t_dp_stat;

endpackage

// ===== rtl/rsta_ctrl.sv =====
// Controller state machine sequencing the distance and average calculations.
module rsta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  rsta_pkg::t_dp_stat i_stat,
    output rsta_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_DIST  = 8'b0000_0100,
        S_AMUL  = 8'b0000_1000,
        S_ANUM  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_AWB   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    rsta_pkg::t_avg_sel r_sel, n_sel;
    logic               r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        o_cmd       = '0;
        o_cmd.avg_sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.sample_ok) begin
                    o_cmd.mul_dist = 1'b1;
                    n_state        = S_DIST;
                end else begin
                    o_cmd.fault = 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_DIST: begin
                o_cmd.calc_dist = 1'b1;
                n_sel           = rsta_pkg::AVG_FAST;
                n_state         = S_AMUL;
            end
            S_AMUL: begin
                o_cmd.mul_avg = 1'b1;
                n_state       = S_ANUM;
            end
            S_ANUM: begin
                o_cmd.form_num = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_AWB;
                end
            end
            S_AWB: begin
                o_cmd.write_avg = 1'b1;
                unique case (r_sel)
                    rsta_pkg::AVG_FAST: begin
                        n_sel   = rsta_pkg::AVG_MEDIUM;
                        n_state = S_AMUL;
                    end
                    rsta_pkg::AVG_MEDIUM: begin
                        n_sel   = rsta_pkg::AVG_SLOW;
                        n_state = S_AMUL;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= rsta_pkg::AVG_FAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/rsta_dp.sv =====
// Datapath: configuration, shared multiplier, serial divider and averages.
module rsta_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rsta_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsta_pkg::DATA_W-1:0]          i_cfg_data,
    input  logic [rsta_pkg::DATA_W-1:0]          i_pulse_period,
    input  logic                                 i_sample_valid,
    input  rsta_pkg::t_dp_cmd                    i_cmd,
    output rsta_pkg::t_dp_stat                   o_stat,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_distance_now,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_fast_average,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_medium_average,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_slow_average,
    output logic [rsta_pkg::DATA_W-1:0]          o_fault_count,
    output logic                                 o_power_cycle
);

    // Configuration registers.
    logic [15:0]        r_scale;
    logic signed [15:0] r_offset;
    logic [9:0]         r_wfast;
    logic [9:0]         r_wslow;

    // Held state.
    logic signed [15:0] r_dist;
    logic signed [15:0] r_avg_fast;
    logic signed [15:0] r_avg_med;
    logic signed [15:0] r_avg_slow;
    logic [15:0]        r_fault;

    // Working registers.
    logic [15:0]        r_ticks;
    logic               r_smp_ok;
    logic signed [33:0] r_prod;
    logic [25:0]        r_dvd;
    logic [10:0]        r_rem;
    logic [10:0]        r_div;
    logic               r_neg;
    logic [rsta_pkg::DIV_CNT_W-1:0] r_cnt;

    // Output registers.
    logic signed [15:0] r_o_dist;
    logic signed [15:0] r_o_fast;
    logic signed [15:0] r_o_med;
    logic signed [15:0] r_o_slow;
    logic [15:0]        r_o_fault;
    logic               r_o_pc;

    logic [9:0]         w_weight;
    logic signed [15:0] w_avg;
    logic signed [16:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [33:0] w_prod;
    logic [19:0]        w_shift;
    logic signed [21:0] w_diff;
    logic signed [15:0] w_dist_sat;
    logic signed [33:0] w_num;
    logic [33:0]        w_mag;
    logic [11:0]        w_step1;
    logic [11:0]        w_step2;
    logic [16:0]        w_q;
    logic [16:0]        w_res;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [11:0] div_bit(input logic [10:0] rem, input logic b,
                                            input logic [10:0] dv);
        logic [11:0] t;
        logic [11:0] d;
        begin
            t = {rem, b};
            d = {1'b0, dv};
            if (t >= d) begin
                div_bit = {1'b1, 11'(t - d)};
            end else begin
                div_bit = {1'b0, t[10:0]};
            end
        end
    endfunction

    always_comb begin
        unique case (i_cmd.avg_sel)
            rsta_pkg::AVG_FAST: begin
                w_weight = r_wfast;
                w_avg    = r_avg_fast;
            end
            rsta_pkg::AVG_MEDIUM: begin
                w_weight = rsta_pkg::MED_WEIGHT;
                w_avg    = r_avg_med;
            end
            default: begin
                w_weight = r_wslow;
                w_avg    = r_avg_slow;
            end
        endcase
    end

    // Shared 17x17 signed multiplier: ticks by scale, or weight by average.
    always_comb begin
        if (i_cmd.mul_avg) begin
            w_mul_a = signed'({7'd0, w_weight});
            w_mul_b = signed'({w_avg[15], w_avg});
        end else begin
            w_mul_a = signed'({1'b0, r_ticks});
            w_mul_b = signed'({1'b0, r_scale});
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    // Distance: product shifted down, offset removed, clamped to 16 bits.
    assign w_shift = r_prod[31:rsta_pkg::SCALE_SHIFT];
    assign w_diff  = signed'({2'b00, w_shift}) - signed'({{6{r_offset[15]}}, r_offset});
    always_comb begin
        if (w_diff > 22'sd32767) begin
            w_dist_sat = 16'sh7FFF;
        end else if (w_diff < -22'sd32768) begin
            w_dist_sat = 16'sh8000;
        end else begin
            w_dist_sat = w_diff[15:0];
        end
    end

    // Numerator and its magnitude; the quotient's sign is restored afterwards.
    assign w_num   = r_prod + signed'({{18{r_dist[15]}}, r_dist});
    assign w_mag   = w_num[33] ? 34'(-w_num) : 34'(w_num);

    assign w_step1 = div_bit(r_rem, r_dvd[25], r_div);
    assign w_step2 = div_bit(w_step1[10:0], r_dvd[24], r_div);

    assign w_q   = r_dvd[16:0];
    assign w_res = r_neg ? 17'(17'd0 - w_q) : w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= '0;
            r_offset   <= '0;
            r_wfast    <= '0;
            r_wslow    <= '0;
            r_dist     <= '0;
            r_avg_fast <= '0;
            r_avg_med  <= '0;
            r_avg_slow <= '0;
            r_fault    <= '0;
            r_cnt      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rsta_pkg::CFG_PERIOD_SCALE:    r_scale  <= i_cfg_data;
                    rsta_pkg::CFG_DISTANCE_OFFSET: r_offset <= signed'(i_cfg_data);
                    rsta_pkg::CFG_FAST_WEIGHT:     r_wfast  <= i_cfg_data[9:0];
                    rsta_pkg::CFG_SLOW_WEIGHT:     r_wslow  <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (i_cmd.calc_dist) begin
                r_dist <= w_dist_sat;
            end
            if (i_cmd.write_avg) begin
                unique case (i_cmd.avg_sel)
                    rsta_pkg::AVG_FAST:   r_avg_fast <= signed'(w_res[15:0]);
                    rsta_pkg::AVG_MEDIUM: r_avg_med  <= signed'(w_res[15:0]);
                    default:              r_avg_slow <= signed'(w_res[15:0]);
                endcase
            end
            if (i_cmd.fault && (r_fault != 16'hFFFF)) begin
                r_fault <= r_fault + 16'd1;
            end
            if (i_cmd.form_num) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ticks  <= i_pulse_period;
            r_smp_ok <= i_sample_valid;
        end
        if (i_cmd.mul_dist || i_cmd.mul_avg) begin
            r_prod <= w_prod;
        end
        if (i_cmd.form_num) begin
            r_neg <= w_num[33];
            r_dvd <= w_mag[25:0];
            r_rem <= '0;
            r_div <= {1'b0, w_weight} + 11'd1;
        end else if (i_cmd.div_step) begin
            r_rem <= w_step2[10:0];
            r_dvd <= {r_dvd[23:0], w_step1[11], w_step2[11]};
        end
        if (i_cmd.load_out) begin
            r_o_dist  <= r_dist;
            r_o_fast  <= r_avg_fast;
            r_o_med   <= r_avg_med;
            r_o_slow  <= r_avg_slow;
            r_o_fault <= r_fault;
            r_o_pc    <= ~r_smp_ok;
        end
    end

    assign o_stat.sample_ok = r_smp_ok;
    assign o_stat.div_done  = (r_cnt == rsta_pkg::DIV_CNT_W'(rsta_pkg::DIV_STEPS - 1));

    assign o_distance_now   = r_o_dist;
    assign o_fast_average   = r_o_fast;
    assign o_medium_average = r_o_med;
    assign o_slow_average   = r_o_slow;
    assign o_fault_count    = r_o_fault;
    assign o_power_cycle    = r_o_pc;

endmodule

// ===== rtl/range_sample_triple_averager.sv =====
// A valid sample passes through the distance step and all three averages before its result
// is registered; an invalid one goes straight to the output. One request at a time: the next
// is taken once the result is registered, and the output stage waits while an earlier result
// is still not taken. The shared serial divider works two quotient bits a cycle on each average.
// Reset: synchronous, active low; clears configuration, distance, averages and fault count.
`include "range_sample_triple_averager_assert.svh"

// Top level of the range sample triple averager.
module range_sample_triple_averager (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Sample request channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [rsta_pkg::DATA_W-1:0]          i_pulse_period,
    input  logic                                 i_sample_valid,
    // Result request channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_distance_now,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_fast_average,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_medium_average,
    output logic signed [rsta_pkg::DATA_W-1:0]   o_slow_average,
    output logic [rsta_pkg::DATA_W-1:0]          o_fault_count,
    output logic                                 o_power_cycle,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rsta_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rsta_pkg::DATA_W-1:0]          i_cfg_data
);

    // The controller walks each sample through the following sequence. A valid sample is
    // first multiplied by the period scale; the next cycle shifts, subtracts the mounting
    // offset and clamps the result into the held distance. Each of the three averages then
    // reuses the same multiplier for weight times old average, adds the new distance, and
    // hands the magnitude of that numerator to the serial divider. The sign is put back on
    // the quotient, which gives truncation towards zero. An invalid sample skips all of
    // this and only bumps the saturating fault count and flags a power cycle in its result.
    rsta_pkg::t_dp_cmd  w_cmd;
    rsta_pkg::t_dp_stat w_stat;

    // Accepted unchecked; the user must issue configuration writes only while the block idles.
    assign o_cfg_ready = 1'b1;

    rsta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the result in its own output registers, so a new sample can be
    // accepted while the previous result still waits to be taken.
    rsta_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pulse_period   (i_pulse_period),
        .i_sample_valid   (i_sample_valid),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_distance_now   (o_distance_now),
        .o_fast_average   (o_fast_average),
        .o_medium_average (o_medium_average),
        .o_slow_average   (o_slow_average),
        .o_fault_count    (o_fault_count),
        .o_power_cycle    (o_power_cycle)
    );

    // A power-cycle result always follows at least one counted fault.
    `RSTA_ASSERT_SAME(a_pc_has_fault, i_clk, i_rst_n, o_out_valid && o_power_cycle,
        o_fault_count != 16'd0, "power cycle reported with zero fault count")

    // Once a sample is taken, the block is busy in the following cycle.
    `RSTA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "sample accepted while still working on the previous one")

endmodule
